// ===== rtl/glofbf_pkg.sv =====
// glofbf_pkg: widths, character codes, register indexes and shared types
// for the G-code laser-off boundary finder. No dependencies.
`timescale 1ns / 1ps

package glofbf_pkg;

    // Field and counter widths
    localparam int FIELD_W        = 18;
    localparam int CFG_IDX_W      = 2;
    localparam int LINE_KEEP_MAX  = 128;
    localparam int KEPT_W         = $clog2(LINE_KEEP_MAX);
    localparam int MAX_JOB_BYTES  = 131072;

    localparam logic [KEPT_W-1:0]  KEEP_LIMIT   = KEPT_W'(LINE_KEEP_MAX - 1);
    localparam logic [FIELD_W-1:0] COUNT_LIMIT  = '1;
    localparam logic [FIELD_W-1:0] REQ_RST      = FIELD_W'(4096);
    localparam logic [FIELD_W-1:0] FALLBACK_RST = FIELD_W'(8192);
    localparam logic [FIELD_W-1:0] JOB_SIZE_RST = FIELD_W'(MAX_JOB_BYTES);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JOB_SIZE = 2'd2;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PAREN = 8'h28;
    localparam logic [7:0] CH_UP_M  = 8'h4D;
    localparam logic [7:0] CH_LO_M  = 8'h6D;
    localparam logic [7:0] CH_UP_S  = 8'h53;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // Kind of the token currently open
    typedef enum logic [1:0] {
        TOK_NONE  = 2'd0,
        TOK_M     = 2'd1,
        TOK_S     = 2'd2,
        TOK_OTHER = 2'd3
    } t_tok_kind;

    // Configuration registers as seen by the scanner
    typedef struct packed {
        logic [FIELD_W-1:0] req_pos;
        logic [FIELD_W-1:0] fb_pos;
        logic [FIELD_W-1:0] job_size;
    } t_cfg;

    // Scanner verdict for the item in the input register
    typedef struct packed {
        logic               fire;
        logic [FIELD_W-1:0] trig_pos;
    } t_scan_res;

endpackage

// ===== rtl/glofbf_cmd_if.sv =====
// glofbf_cmd_if: valid/ready channel carrying command and data bytes.
// Depends on nothing.
`timescale 1ns / 1ps

interface glofbf_cmd_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// ===== rtl/glofbf_trig_if.sv =====
// glofbf_trig_if: valid/ready channel carrying the trigger position.
// Depends on glofbf_pkg for the field width.
`timescale 1ns / 1ps

interface glofbf_trig_if;
    logic                             valid;
    logic                             ready;
    logic [glofbf_pkg::FIELD_W-1:0]   trig_pos;

    modport source (output valid, output trig_pos, input ready);
    modport sink   (input valid, input trig_pos, output ready);
endinterface

// ===== rtl/glofbf_scan.sv =====
// glofbf_scan: byte counter, line tokenizer and laser-state tracking.
// Depends on glofbf_pkg.
`timescale 1ns / 1ps

module glofbf_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic                           i_command,
    input  logic [7:0]                     i_data_byte,
    input  glofbf_pkg::t_cfg               i_cfg,
    output glofbf_pkg::t_scan_res          o_res
);

    typedef struct packed {
        logic [glofbf_pkg::KEPT_W-1:0] kept;
        logic                          cut;
        glofbf_pkg::t_tok_kind         kind;
        logic [1:0]                    len;
        logic                          second_five;
        logic                          tail_zero;
        logic                          saw_laser;
        logic                          last_off;
    } t_line_st;

    localparam t_line_st LINE_CLEAR = '{
        kept: '0, cut: 1'b0, kind: glofbf_pkg::TOK_NONE, len: 2'd0,
        second_five: 1'b0, tail_zero: 1'b1, saw_laser: 1'b0, last_off: 1'b0
    };

    t_line_st                        r_line, n_line;
    logic [glofbf_pkg::FIELD_W-1:0]  r_bytes, n_bytes;
    logic                            r_done, n_done;

    logic [glofbf_pkg::FIELD_W-1:0]  pos;
    logic [glofbf_pkg::FIELD_W-1:0]  eff_fallback;
    logic                            is_eol;
    logic                            close_saw;
    logic                            close_last;
    logic                            fire;

    // Position after this byte, saturating
    assign pos = (r_bytes == glofbf_pkg::COUNT_LIMIT) ? glofbf_pkg::COUNT_LIMIT
                                                      : r_bytes + 1'b1;
    assign is_eol = (i_data_byte == glofbf_pkg::CH_LF) || (i_data_byte == glofbf_pkg::CH_CR);

    // Laser state once the open token is closed
    always_comb begin
        close_saw  = r_line.saw_laser;
        close_last = r_line.last_off;
        case (r_line.kind)
            glofbf_pkg::TOK_M: begin
                close_saw  = 1'b1;
                close_last = (r_line.len == 2'd2) && r_line.second_five;
            end
            glofbf_pkg::TOK_S: begin
                close_saw  = 1'b1;
                close_last = (r_line.len >= 2'd2) && r_line.tail_zero;
            end
            default: ;
        endcase
    end

    // Trigger decision at a line end
    assign eff_fallback = (i_cfg.fb_pos < i_cfg.req_pos) ? i_cfg.req_pos : i_cfg.fb_pos;
    assign fire = (i_command == glofbf_pkg::CMD_DATA) && !r_done && is_eol &&
                  (((pos >= i_cfg.req_pos) && close_saw && close_last) ||
                   (pos >= eff_fallback));

    assign o_res.fire     = fire;
    assign o_res.trig_pos = pos;

    // Next state for one transfer
    always_comb begin
        n_line  = r_line;
        n_bytes = r_bytes;
        n_done  = r_done;
        if (i_step) begin
            if (i_command == glofbf_pkg::CMD_START) begin
                n_bytes = '0;
                n_line  = LINE_CLEAR;
                n_done  = (i_cfg.job_size <= i_cfg.req_pos);
            end else if (!r_done) begin
                n_bytes = pos;
                if (is_eol) begin
                    n_line = LINE_CLEAR;
                    if (fire) begin
                        n_done = 1'b1;
                    end
                end else if (r_line.kept < glofbf_pkg::KEEP_LIMIT) begin
                    n_line.kept = r_line.kept + 1'b1;
                    if (!r_line.cut) begin
                        if ((i_data_byte == glofbf_pkg::CH_SEMI) ||
                            (i_data_byte == glofbf_pkg::CH_PAREN)) begin
                            // comment start: close token, drop rest of line
                            n_line.saw_laser = close_saw;
                            n_line.last_off  = close_last;
                            n_line.kind      = glofbf_pkg::TOK_NONE;
                            n_line.len       = 2'd0;
                            n_line.cut       = 1'b1;
                        end else if ((i_data_byte == glofbf_pkg::CH_SPACE) ||
                                     (i_data_byte == glofbf_pkg::CH_TAB)) begin
                            n_line.saw_laser = close_saw;
                            n_line.last_off  = close_last;
                            n_line.kind      = glofbf_pkg::TOK_NONE;
                            n_line.len       = 2'd0;
                        end else if (r_line.kind == glofbf_pkg::TOK_NONE) begin
                            // first letter opens a token
                            if ((i_data_byte == glofbf_pkg::CH_UP_M) ||
                                (i_data_byte == glofbf_pkg::CH_LO_M)) begin
                                n_line.kind = glofbf_pkg::TOK_M;
                            end else if ((i_data_byte == glofbf_pkg::CH_UP_S) ||
                                         (i_data_byte == glofbf_pkg::CH_LO_S)) begin
                                n_line.kind = glofbf_pkg::TOK_S;
                            end else begin
                                n_line.kind = glofbf_pkg::TOK_OTHER;
                            end
                            n_line.len         = 2'd1;
                            n_line.second_five = 1'b0;
                            n_line.tail_zero   = 1'b1;
                        end else begin
                            if (r_line.len == 2'd1) begin
                                n_line.second_five = (i_data_byte == glofbf_pkg::CH_FIVE);
                            end
                            if (!((i_data_byte == glofbf_pkg::CH_ZERO) ||
                                  (i_data_byte == glofbf_pkg::CH_PLUS) ||
                                  (i_data_byte == glofbf_pkg::CH_MINUS) ||
                                  (i_data_byte == glofbf_pkg::CH_DOT))) begin
                                n_line.tail_zero = 1'b0;
                            end
                            if (r_line.len != 2'd3) begin
                                n_line.len = r_line.len + 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= LINE_CLEAR;
            r_bytes <= '0;
            r_done  <= 1'b1;
        end else begin
            r_line  <= n_line;
            r_bytes <= n_bytes;
            r_done  <= n_done;
        end
    end

    // A start command restarts the position count
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_command == glofbf_pkg::CMD_START)) |=> (r_bytes == '0))
        else $error("byte count not cleared by start");

    // Once fired, the scanner is done until a start command
    a_fire_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && fire) |=> r_done)
        else $error("done not set after trigger");

    // Only a start command leaves the done state
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !(i_step && (i_command == glofbf_pkg::CMD_START))) |=> r_done)
        else $error("done cleared without start");

    // Data bytes never move the counter while done
    a_done_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (i_command == glofbf_pkg::CMD_DATA)) |=> $stable(r_bytes))
        else $error("bytes counted while done");

endmodule

// ===== rtl/gcode_laser_off_boundary_finder_core.sv =====
// gcode_laser_off_boundary_finder_core: top level with input register,
// configuration registers, scanner and result register.
// Depends on glofbf_pkg, glofbf_cmd_if, glofbf_trig_if, glofbf_scan.
//
//  channel   dir  fields                       meaning
//  i_cmd     in   command[0], data_byte[7:0]  start command or G-code byte
//  o_trig    out  trig_pos[17:0]              position after triggering line end
//  i_cfg_*   in   we, idx[1:0], data[17:0]    request/fallback/job_size writes
//
// One transfer per cycle while the input is not stalled: a byte is held in the input
// register, where it is scanned and the state updated; when it leaves, a trigger is
// loaded into the result register, which drives o_trig.valid.
// Reset is synchronous, active low; after reset data bytes are ignored until
// a start command. A result held by a stalled o_trig only blocks a byte that
// would fire again; all other bytes keep flowing.
`timescale 1ns / 1ps

module gcode_laser_off_boundary_finder_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    glofbf_cmd_if.sink                            i_cmd,
    glofbf_trig_if.source                         o_trig,
    input  logic                                  i_cfg_we,
    input  logic [glofbf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [glofbf_pkg::FIELD_W-1:0]        i_cfg_data
);

    logic                            r_in_vld;
    logic                            r_in_cmd;
    logic [7:0]                      r_in_byte;
    logic                            r_out_vld;
    logic [glofbf_pkg::FIELD_W-1:0]  r_out_off;
    glofbf_pkg::t_cfg                r_cfg;
    glofbf_pkg::t_scan_res           scan_res;
    logic                            advance;
    logic                            in_xfer;

    // Item leaves the input register unless it fires into a full result slot
    assign advance = r_in_vld && (!scan_res.fire || !r_out_vld || o_trig.ready);
    assign i_cmd.ready = !r_in_vld || advance;
    assign in_xfer = i_cmd.valid && i_cmd.ready;

    // Configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.req_pos  <= glofbf_pkg::REQ_RST;
            r_cfg.fb_pos   <= glofbf_pkg::FALLBACK_RST;
            r_cfg.job_size <= glofbf_pkg::JOB_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                glofbf_pkg::REG_REQUEST:  r_cfg.req_pos  <= i_cfg_data;
                glofbf_pkg::REG_FALLBACK: r_cfg.fb_pos   <= i_cfg_data;
                glofbf_pkg::REG_JOB_SIZE: r_cfg.job_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_cmd  <= i_cmd.command;
            r_in_byte <= i_cmd.data_byte;
        end
    end

    glofbf_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_command   (r_in_cmd),
        .i_data_byte (r_in_byte),
        .i_cfg       (r_cfg),
        .o_res       (scan_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && scan_res.fire) begin
            r_out_vld <= 1'b1;
        end else if (o_trig.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && scan_res.fire) begin
            r_out_off <= scan_res.trig_pos;
        end
    end

    assign o_trig.valid    = r_out_vld;
    assign o_trig.trig_pos = r_out_off;

    // A fired item always lands in the result register
    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && scan_res.fire) |=> r_out_vld)
        else $error("trigger lost at result register");

    // A held input item is not dropped
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> r_in_vld)
        else $error("stalled input item dropped");

    // A trigger position is always past at least one byte
    a_offset_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && scan_res.fire) |-> (scan_res.trig_pos != '0))
        else $error("trigger at position zero");

endmodule
